@@ sv/adgt_pkg.sv @@
// Package for the affine dependence GCD test block.
// Holds widths, codes, the sequencer state type and the remainder control struct; no dependencies.
package adgt_pkg;

    localparam int MAX_DIMS_DEF  = 8;
    localparam int COEF_BITS_DEF = 32;
    localparam int DIM_BITS      = 3;
    localparam int CNT_BITS      = 4;
    localparam int DIST_BITS     = 33;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_RAW  = 2'd1;
    localparam logic [1:0] KIND_WAR  = 2'd2;
    localparam logic [1:0] KIND_WAW  = 2'd3;

    localparam logic [1:0] BY_ARRAYS = 2'd0;
    localparam logic [1:0] BY_READS  = 2'd1;
    localparam logic [1:0] BY_GCD    = 2'd2;
    localparam logic [1:0] BY_DEP    = 2'd3;

    localparam logic [1:0] VERDICT_SAFE   = 2'd0;
    localparam logic [1:0] VERDICT_REDUCE = 2'd1;
    localparam logic [1:0] VERDICT_UNSAFE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_MOD,
        ST_UPDATE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } rem_ctl_t;

endpackage

@@ sv/affine_dependence_gcd_test_unit.sv @@
// Top level of the affine dependence GCD test: sequencer, pair state, output register.
// Depends on adgt_pkg and adgt_rem_unit.
//
// channel   dir  handshake             payload
// s_axis    in   s_tvalid/s_tready     tdata: dimension fields, tlast: last_dimension,
//                                      tuser: last_pair
// m_axis    out  m_tvalid/m_tready     tdata: result fields
// cfg       in   cfg_valid/cfg_ready   cfg_data: reduction_kernel
//
// Each item runs Euclid's algorithm on the coefficient magnitudes, one remainder per step
// through the shared shift-subtract unit, then one more remainder of the offset difference;
// with both coefficients zero both remainders are skipped.
// s_tready is high only in the idle state; a result waiting on m_tready holds the
// sequencer in its output state until the output register is free.
// Reset is synchronous on aresetn low and clears all pair and kernel state.
module affine_dependence_gcd_test_unit #(
    parameter int MAX_DIMS  = adgt_pkg::MAX_DIMS_DEF,
    parameter int COEF_BITS = adgt_pkg::COEF_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata from bit 0: first_array[8], second_array[8], first_is_write, second_is_write,
    // first_coefficient[32], first_offset[32], second_coefficient[32], second_offset[32],
    // first_loop_var[8], second_loop_var[8], zero fill
    input  logic [167:0] s_tdata,
    // tlast: last_dimension
    input  logic         s_tlast,
    // tuser: last_pair
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata from bit 0: dependent, dependence_kind[2], decided_by[2], failing_dimension[3],
    // dist_valid, distance[33], verdict_valid, verdict[2], zero fill
    output logic [47:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);
    localparam int W = COEF_BITS + 1;

    adgt_pkg::state_t state_reg, state_next;

    logic signed [COEF_BITS-1:0] ca_reg, oa_reg, cb_reg, ob_reg;
    logic [7:0]  arr_a_reg, arr_b_reg, va_reg, vb_reg;
    logic        wa_reg, wb_reg, last_dim_reg, last_pr_reg;
    logic [W-1:0] ga_reg, gb_reg, dm_reg;
    logic        red_reg;

    logic [adgt_pkg::CNT_BITS-1:0] dim_cnt_reg, ruled_dim_reg;
    logic        ruled_reg, seen_reg, several_reg, unit_reg, unsafe_reg;
    logic [7:0]  seen_id_reg;
    logic signed [adgt_pkg::DIST_BITS-1:0] fdist_reg;
    logic        out_valid_reg;
    logic [47:0] out_reg;
    logic        out_load;

    logic               rem_start;
    logic [W-1:0]       rem_a, rem_b, rem_val;
    adgt_pkg::rem_ctl_t rem_ctl;

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] v);
        return v[W-1] ? W'(-v) : v;
    endfunction

    assign s_tready  = (state_reg == adgt_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    // load the result only once the previous one has gone
    assign out_load  = (state_reg == adgt_pkg::ST_OUT) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            adgt_pkg::ST_IDLE:   if (s_tvalid && s_tready) state_next = adgt_pkg::ST_GCD;
            adgt_pkg::ST_GCD:    if (gb_reg == '0) state_next = adgt_pkg::ST_MOD;
            adgt_pkg::ST_MOD:    if (ga_reg == '0 || rem_ctl.done)
                                     state_next = adgt_pkg::ST_UPDATE;
            adgt_pkg::ST_UPDATE: state_next = last_dim_reg ? adgt_pkg::ST_OUT
                                                           : adgt_pkg::ST_IDLE;
            adgt_pkg::ST_OUT:    if (out_load) state_next = adgt_pkg::ST_IDLE;
            default:             state_next = adgt_pkg::ST_IDLE;
        endcase
    end

    // Start a remainder when the unit is free in GCD and MOD phases.
    logic mod_started_reg;
    logic gcd_wait_reg;
    always_comb begin
        rem_start = 1'b0;
        rem_a = ga_reg;
        rem_b = gb_reg;
        case (state_reg)
            adgt_pkg::ST_GCD: rem_start = (gb_reg != '0) && !rem_ctl.busy && !rem_ctl.done
                                          && !gcd_wait_reg;
            adgt_pkg::ST_MOD: begin
                rem_a = dm_reg;
                rem_b = ga_reg;
                rem_start = (ga_reg != '0) && !mod_started_reg;
            end
            default: rem_start = 1'b0;
        endcase
    end

    adgt_rem_unit #(.W(W)) u_rem (
        .aclk(aclk), .aresetn(aresetn), .start(rem_start),
        .dividend(rem_a), .divisor(rem_b), .ctl(rem_ctl), .remainder(rem_val)
    );

    logic a_first;
    logic signed [COEF_BITS-1:0] c_w, c_o, o_w, o_o;
    logic [7:0] v_w, v_o;
    logic divides;
    assign a_first = wa_reg || !wb_reg;
    assign c_w = a_first ? ca_reg : cb_reg;
    assign c_o = a_first ? cb_reg : ca_reg;
    assign o_w = a_first ? oa_reg : ob_reg;
    assign o_o = a_first ? ob_reg : oa_reg;
    assign v_w = a_first ? va_reg : vb_reg;
    assign v_o = a_first ? vb_reg : va_reg;
    // Remainder result sits in dm_reg after MOD; a zero gcd leaves the magnitude itself.
    assign divides = (dm_reg == '0);

    logic seen_n, several_n;
    logic [7:0] id_n;
    logic signed [adgt_pkg::DIST_BITS-1:0] dist_n;
    always_comb begin
        seen_n = seen_reg;
        several_n = several_reg;
        id_n = seen_id_reg;
        if (c_w != '0) begin
            if (!seen_n) begin seen_n = 1'b1; id_n = v_w; end
            else if (v_w != id_n) several_n = 1'b1;
        end
        if (c_o != '0) begin
            if (!seen_n) begin seen_n = 1'b1; id_n = v_o; end
            else if (v_o != id_n) several_n = 1'b1;
        end
        dist_n = adgt_pkg::DIST_BITS'(o_w) - adgt_pkg::DIST_BITS'(o_o);
    end

    logic rule_n;
    logic [adgt_pkg::CNT_BITS-1:0] rdim_n;
    logic dep, known, unsafe_n;
    logic [1:0] kind, by, verd;
    logic [adgt_pkg::DIM_BITS-1:0] fdim;
    logic signed [adgt_pkg::DIST_BITS-1:0] pair_dist;
    always_comb begin
        rule_n = ruled_reg;
        rdim_n = ruled_dim_reg;
        if (!ruled_reg && !divides) begin
            rule_n = 1'b1;
            rdim_n = dim_cnt_reg;
        end
        dep = 1'b0; known = 1'b0; kind = adgt_pkg::KIND_NONE; fdim = '0; pair_dist = '0;
        unsafe_n = unsafe_reg;
        if (arr_a_reg != arr_b_reg) by = adgt_pkg::BY_ARRAYS;
        else if (!wa_reg && !wb_reg) by = adgt_pkg::BY_READS;
        else if (ruled_reg) begin
            by = adgt_pkg::BY_GCD;
            fdim = ruled_dim_reg[adgt_pkg::DIM_BITS-1:0];
        end else begin
            by = adgt_pkg::BY_DEP;
            dep = 1'b1;
            if (!seen_reg) known = 1'b1;
            else if (!several_reg && unit_reg) begin
                known = 1'b1;
                pair_dist = fdist_reg;
            end
            if (wa_reg && wb_reg) kind = adgt_pkg::KIND_WAW;
            else if (!known || pair_dist > 0) kind = adgt_pkg::KIND_RAW;
            else if (pair_dist < 0) kind = adgt_pkg::KIND_WAR;
            else kind = wa_reg ? adgt_pkg::KIND_RAW : adgt_pkg::KIND_WAR;
            unsafe_n = 1'b1;
        end
        verd = adgt_pkg::VERDICT_SAFE;
        if (last_pr_reg) verd = unsafe_n ? adgt_pkg::VERDICT_UNSAFE
                                         : (red_reg ? adgt_pkg::VERDICT_REDUCE
                                                    : adgt_pkg::VERDICT_SAFE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= adgt_pkg::ST_IDLE;
            red_reg         <= 1'b0;
            dim_cnt_reg     <= '0;
            ruled_reg       <= 1'b0;
            ruled_dim_reg   <= '0;
            seen_reg        <= 1'b0;
            seen_id_reg     <= '0;
            several_reg     <= 1'b0;
            unit_reg        <= 1'b0;
            fdist_reg       <= '0;
            unsafe_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
            mod_started_reg <= 1'b0;
            gcd_wait_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) red_reg <= cfg_data;
            if (out_load) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            case (state_reg)
                adgt_pkg::ST_IDLE: begin
                    mod_started_reg <= 1'b0;
                    gcd_wait_reg    <= 1'b0;
                end
                adgt_pkg::ST_GCD: begin
                    if (rem_start) gcd_wait_reg <= 1'b1;
                    if (rem_ctl.done) gcd_wait_reg <= 1'b0;
                end
                adgt_pkg::ST_MOD: if (rem_start) mod_started_reg <= 1'b1;
                adgt_pkg::ST_UPDATE: begin
                    ruled_reg     <= rule_n;
                    ruled_dim_reg <= rdim_n;
                    if (c_w != '0 || c_o != '0) begin
                        seen_reg    <= seen_n;
                        seen_id_reg <= id_n;
                        several_reg <= several_n;
                        if (!seen_reg) begin
                            unit_reg  <= (c_w == COEF_BITS'(1)) && (c_o == COEF_BITS'(1));
                            fdist_reg <= dist_n;
                        end
                    end
                    if (32'(dim_cnt_reg) < MAX_DIMS - 1) dim_cnt_reg <= dim_cnt_reg + 1'b1;
                end
                adgt_pkg::ST_OUT: if (out_load) begin
                    unsafe_reg    <= last_pr_reg ? 1'b0 : unsafe_n;
                    dim_cnt_reg   <= '0;
                    ruled_reg     <= 1'b0;
                    ruled_dim_reg <= '0;
                    seen_reg      <= 1'b0;
                    seen_id_reg   <= '0;
                    several_reg   <= 1'b0;
                    unit_reg      <= 1'b0;
                    fdist_reg     <= '0;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers: capture, Euclid steps, final remainder, result register.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            arr_a_reg    <= s_tdata[7:0];
            arr_b_reg    <= s_tdata[15:8];
            wa_reg       <= s_tdata[16];
            wb_reg       <= s_tdata[17];
            ca_reg       <= s_tdata[18 +: COEF_BITS];
            oa_reg       <= s_tdata[50 +: COEF_BITS];
            cb_reg       <= s_tdata[82 +: COEF_BITS];
            ob_reg       <= s_tdata[114 +: COEF_BITS];
            va_reg       <= s_tdata[146 +: 8];
            vb_reg       <= s_tdata[154 +: 8];
            last_dim_reg <= s_tlast;
            last_pr_reg  <= s_tuser;
            ga_reg <= mag(W'(signed'(s_tdata[18 +: COEF_BITS])));
            gb_reg <= mag(W'(signed'(s_tdata[82 +: COEF_BITS])));
            dm_reg <= mag(W'(signed'(s_tdata[114 +: COEF_BITS]))
                        - W'(signed'(s_tdata[50 +: COEF_BITS])));
        end else if (state_reg == adgt_pkg::ST_GCD && rem_ctl.done) begin
            ga_reg <= gb_reg;
            gb_reg <= rem_val;
        end else if (state_reg == adgt_pkg::ST_MOD && rem_ctl.done) begin
            dm_reg <= rem_val;
        end
        if (out_load) begin
            out_reg <= {3'b000, verd, last_pr_reg, pair_dist, known, fdim, by, kind, dep};
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == adgt_pkg::ST_OUT |=> out_valid_reg)
        else $error("result not presented");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !rem_ctl.busy)
        else $error("ready while remainder unit busy");
endmodule

@@ sv/adgt_rem_unit.sv @@
// Shift-subtract remainder unit: one quotient bit per cycle.
// Depends on adgt_pkg for the control struct.
module adgt_rem_unit #(
    parameter int W = 33
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [W-1:0]      dividend,
    input  logic [W-1:0]      divisor,
    output adgt_pkg::rem_ctl_t ctl,
    output logic [W-1:0]      remainder
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  quo_reg, quo_next;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  div_reg, div_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [W:0]    trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[W-1:0], quo_reg[W-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[W-2:0], 1'b0};
            if (trial >= {1'b0, div_reg}) rem_next = trial - {1'b0, div_reg};
            else rem_next = trial;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign remainder = rem_reg[W-1:0];
    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> !busy_reg)
        else $error("remainder done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && cnt_reg == CW'(1) && !start |=> done_reg)
        else $error("remainder finish missed");
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |=> !done_reg)
        else $error("done longer than one cycle");
endmodule

@@ bench/affine_dependence_gcd_test_unit_test.sv @@
// Bench for affine_dependence_gcd_test_unit: drives array-reference dimensions, predicts
// each pair result and kernel verdict in-bench, and checks every result item field by field.
// Depends on adgt_pkg and the block's RTL.
`timescale 1ns / 1ps

module affine_dependence_gcd_test_unit_test;

    localparam longint CYCLE_LIMIT = 6000000;
    localparam int     SETTLE      = 2500;

    typedef struct {
        logic [7:0]         arr_a;
        logic [7:0]         arr_b;
        logic               wr_a;
        logic               wr_b;
        logic signed [31:0] coef_a;
        logic signed [31:0] offs_a;
        logic signed [31:0] coef_b;
        logic signed [31:0] offs_b;
        logic [7:0]         var_a;
        logic [7:0]         var_b;
        logic               last_dim;
        logic               last_pair;
        logic               drain_first;
    } dim_item_t;

    typedef struct {
        logic        dependent;
        logic [1:0]  kind;
        logic [1:0]  decided_by;
        logic [2:0]  fail_dim;
        logic        dist_known;
        logic [32:0] distance;
        logic        verdict_valid;
        logic [1:0]  verdict;
    } pair_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [167:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [47:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data = 1'b0;

    dim_item_t    pending_dims[$];
    pair_result_t predicted_results[$];
    dim_item_t    in_flight;
    int           gap_left = 0;
    int           error_count = 0;
    longint       cycle_count = 0;

    // predictor state
    logic         reduction_kernel = 1'b0;
    int           dim_count = 0;
    logic         gcd_ruled = 1'b0;
    int           ruled_dim = 0;
    logic         idx_seen = 1'b0;
    logic [7:0]   seen_id = '0;
    logic         many_idx = 1'b0;
    logic         unit_coefs = 1'b0;
    longint       first_dist = 0;
    logic         kernel_unsafe = 1'b0;

    affine_dependence_gcd_test_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic longint unsigned magnitude(input longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned euclid(input longint unsigned a,
                                               input longint unsigned b);
        longint unsigned t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    task automatic enqueue(input dim_item_t d);
        pending_dims.insert(pending_dims.size(), d);
    endtask

    task automatic note_index(input logic [7:0] id);
        if (!idx_seen) begin
            idx_seen = 1'b1;
            seen_id = id;
        end else if (id != seen_id) begin
            many_idx = 1'b1;
        end
    endtask

    task automatic apply_dimension(input dim_item_t d);
        longint ca, oa, cb, ob, cw, ow, co, oo, pair_dist;
        logic [7:0] vw, vo;
        logic a_first, divides, first_var;
        longint unsigned g, dm;
        pair_result_t r;
        ca = d.coef_a; oa = d.offs_a; cb = d.coef_b; ob = d.offs_b;
        a_first = d.wr_a || !d.wr_b;
        cw = a_first ? ca : cb;  ow = a_first ? oa : ob;
        co = a_first ? cb : ca;  oo = a_first ? ob : oa;
        vw = a_first ? d.var_a : d.var_b;
        vo = a_first ? d.var_b : d.var_a;
        g = euclid(magnitude(ca), magnitude(cb));
        dm = magnitude(ob - oa);
        divides = (g == 0) ? (dm == 0) : (dm % g == 0);
        if (!divides && !gcd_ruled) begin
            gcd_ruled = 1'b1;
            ruled_dim = dim_count;
        end
        if (cw != 0 || co != 0) begin
            first_var = !idx_seen;
            if (cw != 0) note_index(vw);
            if (co != 0) note_index(vo);
            if (first_var) begin
                unit_coefs = (cw == 1 && co == 1);
                first_dist = ow - oo;
            end
        end
        if (dim_count < adgt_pkg::MAX_DIMS_DEF - 1) dim_count++;
        if (!d.last_dim) return;

        r = '{dependent: 1'b0, kind: adgt_pkg::KIND_NONE, decided_by: adgt_pkg::BY_ARRAYS,
              fail_dim: 3'd0, dist_known: 1'b0, distance: '0, verdict_valid: 1'b0,
              verdict: adgt_pkg::VERDICT_SAFE};
        pair_dist = 0;
        if (d.arr_a != d.arr_b) begin
            r.decided_by = adgt_pkg::BY_ARRAYS;
        end else if (!d.wr_a && !d.wr_b) begin
            r.decided_by = adgt_pkg::BY_READS;
        end else if (gcd_ruled) begin
            r.decided_by = adgt_pkg::BY_GCD;
            r.fail_dim = ruled_dim[2:0];
        end else begin
            r.decided_by = adgt_pkg::BY_DEP;
            r.dependent = 1'b1;
            if (!idx_seen) begin
                r.dist_known = 1'b1;
            end else if (!many_idx && unit_coefs) begin
                r.dist_known = 1'b1;
                pair_dist = first_dist;
            end
            if (d.wr_a && d.wr_b) r.kind = adgt_pkg::KIND_WAW;
            else if (!r.dist_known || pair_dist > 0) r.kind = adgt_pkg::KIND_RAW;
            else if (pair_dist < 0) r.kind = adgt_pkg::KIND_WAR;
            else r.kind = d.wr_a ? adgt_pkg::KIND_RAW : adgt_pkg::KIND_WAR;
            kernel_unsafe = 1'b1;
        end
        r.distance = pair_dist[32:0];
        if (d.last_pair) begin
            r.verdict_valid = 1'b1;
            r.verdict = kernel_unsafe ? adgt_pkg::VERDICT_UNSAFE
                                      : (reduction_kernel ? adgt_pkg::VERDICT_REDUCE
                                                          : adgt_pkg::VERDICT_SAFE);
            kernel_unsafe = 1'b0;
        end
        predicted_results.insert(predicted_results.size(), r);
        dim_count = 0; gcd_ruled = 1'b0; ruled_dim = 0; idx_seen = 1'b0; seen_id = '0;
        many_idx = 1'b0; unit_coefs = 1'b0; first_dist = 0;
    endtask

    function automatic dim_item_t mk(input logic [7:0] aa, input logic [7:0] ab,
                                     input logic wa, input logic wb,
                                     input int ca, input int oa, input int cb, input int ob,
                                     input logic [7:0] va, input logic [7:0] vb,
                                     input logic ld, input logic lp);
        dim_item_t d;
        d = '{arr_a: aa, arr_b: ab, wr_a: wa, wr_b: wb, coef_a: ca, offs_a: oa,
              coef_b: cb, offs_b: ob, var_a: va, var_b: vb, last_dim: ld,
              last_pair: lp, drain_first: 1'b0};
        return d;
    endfunction

    function automatic int rand_coef();
        case ($urandom_range(0, 11))
            0, 1, 2:    return 1;
            3:          return 0;
            4:          return -1;
            5:          return $urandom();
            default:    return int'($urandom_range(0, 12)) - 6;
        endcase
    endfunction

    function automatic int rand_offset();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return 0;
            default: return int'($urandom_range(0, 40)) - 20;
        endcase
    endfunction

    task automatic add_pair(input int ndims, input logic lp);
        logic [7:0] aa, ab;
        logic wa, wb, noisy;
        noisy = ($urandom_range(0, 9) == 0);
        aa = noisy ? 8'($urandom()) : 8'($urandom_range(0, 3));
        ab = ($urandom_range(0, 4) != 0) ? aa : 8'($urandom());
        wa = 1'($urandom_range(0, 1));
        wb = 1'($urandom_range(0, 1));
        for (int k = 0; k < ndims; k++) begin
            enqueue(mk(aa, ab, wa, wb, rand_coef(), rand_offset(),
                rand_coef(), rand_offset(),
                noisy ? 8'($urandom()) : 8'($urandom_range(0, 2)),
                noisy ? 8'($urandom()) : 8'($urandom_range(0, 2)),
                k == ndims - 1, lp && k == ndims - 1));
        end
    endtask

    task automatic random_phase(input int items);
        int sent, nd;
        sent = 0;
        while (sent < items) begin
            nd = ($urandom_range(0, 14) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 4);
            add_pair(nd, $urandom_range(0, 7) == 0);
            if ($urandom_range(0, 30) == 0)
                pending_dims[pending_dims.size() - nd].drain_first = 1'b1;
            sent += nd;
        end
        // close the kernel so the phase ends idle
        pending_dims[pending_dims.size() - 1].last_pair = 1'b1;
    endtask

    task automatic wait_idle();
        while (pending_dims.size() != 0 || s_tvalid || predicted_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reduction(input logic v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        reduction_kernel = v;
        cfg_valid <= 1'b0;
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) apply_dimension(in_flight);
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (pending_dims.size() > 0 &&
                             !(pending_dims[0].drain_first && predicted_results.size() > 0))
                begin
                    in_flight = pending_dims.pop_front();
                    s_tdata <= 168'({in_flight.var_b, in_flight.var_a, in_flight.offs_b,
                                     in_flight.coef_b, in_flight.offs_a, in_flight.coef_a,
                                     in_flight.wr_b, in_flight.wr_a,
                                     in_flight.arr_b, in_flight.arr_a});
                    s_tlast <= in_flight.last_dim;
                    s_tuser <= in_flight.last_pair;
                    s_tvalid <= 1'b1;
                    if ($urandom_range(0, 2) != 0) gap_left = 0;
                    else if ($urandom_range(0, 9) != 0) gap_left = $urandom_range(1, 4);
                    else gap_left = $urandom_range(20, 150);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor and watchdog
    always @(posedge aclk) begin
        pair_result_t e;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $error("result item with none expected: %h", m_tdata);
                    error_count++;
                end else begin
                    e = predicted_results.pop_front();
                    if (m_tdata[0] !== e.dependent) begin
                        $error("dependent: expected %0d got %0d", e.dependent, m_tdata[0]);
                        error_count++;
                    end
                    if (m_tdata[2:1] !== e.kind) begin
                        $error("dependence_kind: expected %0d got %0d", e.kind, m_tdata[2:1]);
                        error_count++;
                    end
                    if (m_tdata[4:3] !== e.decided_by) begin
                        $error("decided_by: expected %0d got %0d", e.decided_by, m_tdata[4:3]);
                        error_count++;
                    end
                    if (m_tdata[7:5] !== e.fail_dim) begin
                        $error("failing_dimension: expected %0d got %0d", e.fail_dim,
                               m_tdata[7:5]);
                        error_count++;
                    end
                    if (m_tdata[8] !== e.dist_known) begin
                        $error("dist_valid: expected %0d got %0d", e.dist_known,
                               m_tdata[8]);
                        error_count++;
                    end
                    if (m_tdata[41:9] !== e.distance) begin
                        $error("distance: expected %0d got %0d", $signed(e.distance),
                               $signed(m_tdata[41:9]));
                        error_count++;
                    end
                    if (m_tdata[42] !== e.verdict_valid) begin
                        $error("verdict_valid: expected %0d got %0d", e.verdict_valid,
                               m_tdata[42]);
                        error_count++;
                    end
                    if (m_tdata[44:43] !== e.verdict) begin
                        $error("verdict: expected %0d got %0d", e.verdict, m_tdata[44:43]);
                        error_count++;
                    end
                end
            end
            if ($urandom_range(0, 3) != 0) m_tready <= 1'b1;
            else if ($urandom_range(0, 9) != 0) m_tready <= 1'b0;
            else m_tready <= ($urandom_range(0, 30) == 0);
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: scalar pair, filters, gcd cases, distances and classes
        enqueue(mk(1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        enqueue(mk(1, 2, 1, 1, 1, 0, 1, 0, 0, 0, 1, 0));
        enqueue(mk(3, 3, 0, 0, 1, 0, 1, 0, 0, 0, 1, 1));
        enqueue(mk(4, 4, 1, 0, 2, 0, 2, 1, 0, 0, 1, 0));
        enqueue(mk(4, 4, 0, 1, 0, 3, 0, 5, 0, 0, 1, 0));
        enqueue(mk(5, 5, 1, 0, 1, 2, 1, 0, 7, 7, 1, 0));
        enqueue(mk(5, 5, 0, 1, 1, 2, 1, 0, 7, 7, 1, 0));
        enqueue(mk(5, 5, 1, 0, 1, 0, 1, 0, 7, 7, 1, 0));
        enqueue(mk(5, 5, 0, 1, 1, 4, 1, 4, 7, 7, 1, 0));
        enqueue(mk(6, 6, 1, 1, 1, 1, 1, 3, 1, 1, 1, 0));
        enqueue(mk(6, 6, 1, 0, 1, 0, 1, 1, 1, 1, 0, 0));
        enqueue(mk(6, 6, 1, 0, 1, 0, 1, 0, 2, 2, 1, 1));
        enqueue(mk(8, 8, 1, 0, 3, 0, 6, 9, 4, 4, 1, 1));
        // too many dimensions: failure on the tenth saturates the counter
        for (int k = 0; k < 10; k++)
            enqueue(mk(9, 9, 1, 0, 2, 0, 2, (k == 9), 1, 1, k == 9, 0));
        enqueue(mk(255, 255, 1, 1, 32'h8000_0000, 32'h8000_0000,
                   32'h7fff_ffff, 32'h7fff_ffff, 255, 255, 1, 0));
        enqueue(mk(0, 0, 1, 0, 1, 32'h8000_0000, 1, 32'h7fff_ffff,
                   255, 255, 1, 1));
        wait_idle();

        write_reduction(1'b1);
        enqueue(mk(2, 2, 0, 0, 1, 0, 1, 0, 0, 0, 1, 1));
        random_phase(150);
        pending_dims[0].drain_first = 1'b1;
        wait_idle();

        write_reduction(1'b0);
        random_phase(150);
        wait_idle();

        write_reduction(1'b1);
        random_phase(280);
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
